// ===== rtl/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, types and codes of the triangle facet normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int IDX_BITS      = 10;
  localparam int COORD_BITS    = 24;
  localparam int NODE_BITS     = 3 * COORD_BITS;
  localparam int EDGE_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = 2 * EDGE_BITS;
  localparam int CROSS_BITS    = PROD_BITS + 1;
  localparam int SUM_BITS      = PROD_BITS;
  localparam int THR_BITS      = 50;
  localparam int OUT_BITS      = 52;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_IDX_LSB   = 3;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // register index
  localparam logic REG_THRESHOLD = 1'b0;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EDGE_BITS-1:0]  edge_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic [SUM_BITS-1:0]          sum_t;
  typedef logic signed [OUT_BITS-1:0]   out_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } node_t;

endpackage

// ===== rtl/tfn_if.sv =====
// ----------------------------------------------------------------------------
// tfn channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tfn_in_if import tfn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [IDX_BITS-1:0] node_index;
  coord_t              point_x;
  coord_t              point_y;
  coord_t              point_z;
  logic [IDX_BITS-1:0] corner_a;
  logic [IDX_BITS-1:0] corner_b;
  logic [IDX_BITS-1:0] corner_c;
  logic                reversed;

  modport source (
    output valid, kind, node_index, point_x, point_y, point_z,
           corner_a, corner_b, corner_c, reversed,
    input  ready
  );
  modport sink (
    input  valid, kind, node_index, point_x, point_y, point_z,
           corner_a, corner_b, corner_c, reversed,
    output ready
  );
endinterface

interface tfn_out_if import tfn_pkg::*; ();
  logic valid;
  logic ready;
  out_t normal_x;
  out_t normal_y;
  out_t normal_z;
  logic degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

// ===== rtl/tfn_ram.sv =====
// ----------------------------------------------------------------------------
// tfn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/triangle_facet_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_facet_normal
// Pipeline: table read, edge, product, sum and output registers, in order.
// Throughput: one item per cycle; three copies of the node table serve the
//   three corner reads, and each stage stalls only when it and all later
//   stages are full. Load items write all three copies and give no result.
// Reset: clears the valid bits and the threshold register; the node table
//   is not cleared and must be loaded before it is read.
// ----------------------------------------------------------------------------
module triangle_facet_normal import tfn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  tfn_in_if.sink                   in_ch,
  tfn_out_if.source                out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  // ---------------- configuration ----------------
  logic [THR_BITS-1:0] thr_r;
  logic [THR_BITS-1:0] thr_nxt;
  logic                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_wr && (cfg_paddr[CFG_IDX_LSB] == REG_THRESHOLD)) begin
      thr_nxt = cfg_pwdata[THR_BITS-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_IDX_LSB] == REG_THRESHOLD) begin
      cfg_prdata = {{(CFG_DATA_BITS-THR_BITS){1'b0}}, thr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // ---------------- stage enables ----------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic en1, en2, en3, en4, en5;
  logic in_acc;

  assign en5 = !out_v_r || out_ch.ready;
  assign en4 = !s4_v_r || en5;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;

  assign in_ch.ready = en1;
  assign in_acc      = in_ch.valid && en1;

  // ---------------- stage 1: node table reads ----------------
  logic                we;
  logic [IDX_BITS-1:0] raddr [3];
  logic [NODE_BITS-1:0] rdata [3];
  node_t               p [3];

  assign we       = in_acc && (in_ch.kind == KIND_LOAD);
  assign raddr[0] = in_ch.corner_a;
  assign raddr[1] = in_ch.reversed ? in_ch.corner_c : in_ch.corner_b;
  assign raddr[2] = in_ch.reversed ? in_ch.corner_b : in_ch.corner_c;

  for (genvar g = 0; g < 3; g++) begin : g_tbl
    tfn_ram #(
      .WIDTH (NODE_BITS),
      .DEPTH (NODE_COUNT)
    ) u_tbl (
      .clk   (clk),
      .we    (we),
      .waddr (in_ch.node_index),
      .wdata ({in_ch.point_x, in_ch.point_y, in_ch.point_z}),
      .re    (en1),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
    assign p[g] = node_t'(rdata[g]);
  end

  // ---------------- stage 2: edges ----------------
  edge_t v1_nxt [3], v2_nxt [3], v3_nxt [3];
  edge_t s2_v1_r [3], s2_v2_r [3], s2_v3_r [3];

  always_comb begin
    v1_nxt[0] = EDGE_BITS'(p[1].x) - EDGE_BITS'(p[0].x);
    v1_nxt[1] = EDGE_BITS'(p[1].y) - EDGE_BITS'(p[0].y);
    v1_nxt[2] = EDGE_BITS'(p[1].z) - EDGE_BITS'(p[0].z);
    v2_nxt[0] = EDGE_BITS'(p[2].x) - EDGE_BITS'(p[1].x);
    v2_nxt[1] = EDGE_BITS'(p[2].y) - EDGE_BITS'(p[1].y);
    v2_nxt[2] = EDGE_BITS'(p[2].z) - EDGE_BITS'(p[1].z);
    v3_nxt[0] = EDGE_BITS'(p[0].x) - EDGE_BITS'(p[2].x);
    v3_nxt[1] = EDGE_BITS'(p[0].y) - EDGE_BITS'(p[2].y);
    v3_nxt[2] = EDGE_BITS'(p[0].z) - EDGE_BITS'(p[2].z);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_v1_r <= v1_nxt;
      s2_v2_r <= v2_nxt;
      s2_v3_r <= v3_nxt;
    end
  end

  // ---------------- stage 3: products ----------------
  prod_t sq1_nxt [3], sq2_nxt [3], sq3_nxt [3];
  prod_t s3_sq1_r [3], s3_sq2_r [3], s3_sq3_r [3];
  prod_t cr_nxt [6];
  prod_t s3_cr_r [6];
  edge_t s3_v1_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq1_nxt[k] = s2_v1_r[k] * s2_v1_r[k];
      sq2_nxt[k] = s2_v2_r[k] * s2_v2_r[k];
      sq3_nxt[k] = s2_v3_r[k] * s2_v3_r[k];
    end
    // terms of v1 x v2, in pairs per component
    cr_nxt[0] = s2_v1_r[1] * s2_v2_r[2];
    cr_nxt[1] = s2_v1_r[2] * s2_v2_r[1];
    cr_nxt[2] = s2_v1_r[2] * s2_v2_r[0];
    cr_nxt[3] = s2_v1_r[0] * s2_v2_r[2];
    cr_nxt[4] = s2_v1_r[0] * s2_v2_r[1];
    cr_nxt[5] = s2_v1_r[1] * s2_v2_r[0];
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sq1_r <= sq1_nxt;
      s3_sq2_r <= sq2_nxt;
      s3_sq3_r <= sq3_nxt;
      s3_cr_r  <= cr_nxt;
      s3_v1_r  <= s2_v1_r;
    end
  end

  // ---------------- stage 4: sums ----------------
  sum_t   len_nxt [3];
  sum_t   s4_len_r [3];
  cross_t cross_nxt [3];
  cross_t s4_cross_r [3];
  edge_t  s4_v1_r [3];

  always_comb begin
    // squares are non-negative and below 2**48, so the sum fits unsigned
    len_nxt[0] = sum_t'(s3_sq1_r[0]) + sum_t'(s3_sq1_r[1]) + sum_t'(s3_sq1_r[2]);
    len_nxt[1] = sum_t'(s3_sq2_r[0]) + sum_t'(s3_sq2_r[1]) + sum_t'(s3_sq2_r[2]);
    len_nxt[2] = sum_t'(s3_sq3_r[0]) + sum_t'(s3_sq3_r[1]) + sum_t'(s3_sq3_r[2]);
    for (int k = 0; k < 3; k++) begin
      cross_nxt[k] = CROSS_BITS'(s3_cr_r[2*k]) - CROSS_BITS'(s3_cr_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_len_r   <= len_nxt;
      s4_cross_r <= cross_nxt;
      s4_v1_r    <= s3_v1_r;
    end
  end

  // ---------------- stage 5: threshold test and output ----------------
  logic pass;
  out_t nrm_nxt [3];
  out_t nrm_r [3];
  logic deg_r;

  assign pass = (s4_len_r[0] > thr_r) && (s4_len_r[1] > thr_r) && (s4_len_r[2] > thr_r);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pass) begin
        nrm_nxt[k] = {{(OUT_BITS-CROSS_BITS){s4_cross_r[k][CROSS_BITS-1]}}, s4_cross_r[k]};
      end else begin
        nrm_nxt[k] = {{(OUT_BITS-EDGE_BITS){s4_v1_r[k][EDGE_BITS-1]}}, s4_v1_r[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      nrm_r <= nrm_nxt;
      deg_r <= !pass;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.normal_x   = nrm_r[0];
  assign out_ch.normal_y   = nrm_r[1];
  assign out_ch.normal_z   = nrm_r[2];
  assign out_ch.degenerate = deg_r;

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r  <= in_ch.valid && (in_ch.kind == KIND_QUERY);
      if (en2) s2_v_r  <= s1_v_r;
      if (en3) s3_v_r  <= s2_v_r;
      if (en4) s4_v_r  <= s3_v_r;
      if (en5) out_v_r <= s4_v_r;
    end
  end

  // ---------------- assertions ----------------
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.kind == KIND_LOAD)) |=> !s1_v_r)
    else $error("load item entered the result pipeline");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_v_r))
    else $error("input stalled with a bubble in the pipeline");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !en3) |=> (s2_v_r && $stable(s2_v1_r[0]) && $stable(s2_v2_r[2])))
    else $error("stalled edge stage lost its item");

  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && !en5) |=> (s4_v_r && $stable(s4_len_r[0]) && $stable(s4_cross_r[1])))
    else $error("stalled sum stage lost its item");

endmodule

// ===== tb/sv/triangle_facet_normal_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_facet_normal_tb
// Loads nodes into the table and sends triangle queries. A copy of the table
// and the threshold in the bench predicts each facet normal or degenerate
// edge, and every result is checked in order. Thresholds range from zero to
// full scale, and both channels stall at random.
// ----------------------------------------------------------------------------
module triangle_facet_normal_tb;
  import tfn_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PIPE_SETTLE = 10;
  localparam int          IDLE_PCT    = 22;
  localparam logic [CFG_ADDR_BITS-1:0] THRESHOLD_ADDR =
    CFG_ADDR_BITS'(REG_THRESHOLD) << CFG_IDX_LSB;
  localparam coord_t      COORD_MIN   = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t      COORD_MAX   = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [THR_BITS-1:0] THR_FULL = '1;

  typedef struct {
    logic                kind;
    logic [IDX_BITS-1:0] node_index;
    coord_t              point_x;
    coord_t              point_y;
    coord_t              point_z;
    logic [IDX_BITS-1:0] corner_a;
    logic [IDX_BITS-1:0] corner_b;
    logic [IDX_BITS-1:0] corner_c;
    logic                reversed;
  } mesh_item_t;

  typedef struct {
    out_t normal_x;
    out_t normal_y;
    out_t normal_z;
    logic degenerate;
  } facet_t;

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  logic clk;
  logic rst_n;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  tfn_in_if  in_ch ();
  tfn_out_if out_ch ();

  triangle_facet_normal uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // bench copy of the block state
  node_t               node_table [NODE_COUNT];
  bit                  node_loaded [NODE_COUNT];
  logic [IDX_BITS-1:0] loaded_nodes [$];
  logic [THR_BITS-1:0] threshold_reg;

  facet_t      pending_normals [$];
  int          mismatches  = 0;
  bit          steady      = 1'b0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic vec3_t edge_vec(node_t from_p, node_t to_p);
    vec3_t d;
    d.x = longint'($signed(to_p.x)) - longint'($signed(from_p.x));
    d.y = longint'($signed(to_p.y)) - longint'($signed(from_p.y));
    d.z = longint'($signed(to_p.z)) - longint'($signed(from_p.z));
    return d;
  endfunction

  function automatic longint mag2(vec3_t d);
    return d.x * d.x + d.y * d.y + d.z * d.z;
  endfunction

  function automatic facet_t facet_normal_of(mesh_item_t it);
    node_t  p1, p2, p3;
    vec3_t  v1, v2, v3;
    longint thr;
    facet_t r;
    p1  = node_table[it.corner_a];
    p2  = it.reversed ? node_table[it.corner_c] : node_table[it.corner_b];
    p3  = it.reversed ? node_table[it.corner_b] : node_table[it.corner_c];
    v1  = edge_vec(p1, p2);
    v2  = edge_vec(p2, p3);
    v3  = edge_vec(p3, p1);
    thr = longint'(threshold_reg);
    if (mag2(v1) > thr && mag2(v2) > thr && mag2(v3) > thr) begin
      r.normal_x   = out_t'(v1.y * v2.z - v1.z * v2.y);
      r.normal_y   = out_t'(v1.z * v2.x - v1.x * v2.z);
      r.normal_z   = out_t'(v1.x * v2.y - v1.y * v2.x);
      r.degenerate = 1'b0;
    end else begin
      r.normal_x   = out_t'(v1.x);
      r.normal_y   = out_t'(v1.y);
      r.normal_z   = out_t'(v1.z);
      r.degenerate = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checker
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    facet_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_normals.size() == 0) begin
        $error("result item with no query pending");
        mismatches++;
      end else begin
        want = pending_normals.pop_front();
        if (out_ch.normal_x !== want.normal_x) begin
          $error("normal_x: expected %0d, got %0d", want.normal_x, out_ch.normal_x);
          mismatches++;
        end
        if (out_ch.normal_y !== want.normal_y) begin
          $error("normal_y: expected %0d, got %0d", want.normal_y, out_ch.normal_y);
          mismatches++;
        end
        if (out_ch.normal_z !== want.normal_z) begin
          $error("normal_z: expected %0d, got %0d", want.normal_z, out_ch.normal_z);
          mismatches++;
        end
        if (out_ch.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0d, got %0d", want.degenerate, out_ch.degenerate);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  // all driver tasks start and end at a falling edge
  task automatic send_item(input mesh_item_t it);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= it.kind;
    in_ch.node_index <= it.node_index;
    in_ch.point_x    <= it.point_x;
    in_ch.point_y    <= it.point_y;
    in_ch.point_z    <= it.point_z;
    in_ch.corner_a   <= it.corner_a;
    in_ch.corner_b   <= it.corner_b;
    in_ch.corner_c   <= it.corner_c;
    in_ch.reversed   <= it.reversed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (it.kind == KIND_LOAD) begin
      node_table[it.node_index] = {it.point_x, it.point_y, it.point_z};
      if (!node_loaded[it.node_index]) begin
        node_loaded[it.node_index] = 1'b1;
        loaded_nodes.push_back(it.node_index);
      end
    end else begin
      pending_normals.push_back(facet_normal_of(it));
    end
    @(negedge clk);
  endtask

  task automatic load_node(input logic [IDX_BITS-1:0] idx, input node_t p);
    mesh_item_t it;
    it.kind       = KIND_LOAD;
    it.node_index = idx;
    it.point_x    = p.x;
    it.point_y    = p.y;
    it.point_z    = p.z;
    // corner fields are don't-care on a load
    it.corner_a   = IDX_BITS'($urandom);
    it.corner_b   = IDX_BITS'($urandom);
    it.corner_c   = IDX_BITS'($urandom);
    it.reversed   = 1'($urandom);
    send_item(it);
  endtask

  task automatic query_facet(input logic [IDX_BITS-1:0] a, b, c, input logic rev);
    mesh_item_t it;
    it.kind       = KIND_QUERY;
    it.node_index = IDX_BITS'($urandom);
    it.point_x    = coord_t'($urandom);
    it.point_y    = coord_t'($urandom);
    it.point_z    = coord_t'($urandom);
    it.corner_a   = a;
    it.corner_b   = b;
    it.corner_c   = c;
    it.reversed   = rev;
    send_item(it);
  endtask

  task automatic write_threshold(input logic [THR_BITS-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= THRESHOLD_ADDR;
    cfg_pwdata  <= CFG_DATA_BITS'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    threshold_reg = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // loads give no result, so let the pipe run empty after the last query
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic coord_t extreme_coord();
    case ($urandom_range(4))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return coord_t'(1);
    endcase
  endfunction

  function automatic coord_t small_coord();
    return coord_t'(int'($urandom_range(128)) - 64);
  endfunction

  function automatic logic [IDX_BITS-1:0] pick_loaded();
    return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
  endfunction

  function automatic node_t rand_node();
    node_t p;
    node_t base;
    case ($urandom_range(4))
      0: p = node_t'({$urandom, $urandom, $urandom});
      1: p = {small_coord(), small_coord(), small_coord()};
      2: p = {extreme_coord(), extreme_coord(), extreme_coord()};
      3: p = {coord_t'(int'($urandom_range(8191)) - 4096),
              coord_t'(int'($urandom_range(8191)) - 4096),
              coord_t'(int'($urandom_range(8191)) - 4096)};
      default: begin
        // close to an existing node, for short edges
        base = node_table[pick_loaded()];
        p.x  = base.x + small_coord();
        p.y  = base.y + small_coord();
        p.z  = base.z + small_coord();
      end
    endcase
    return p;
  endfunction

  task automatic test_directed_extremes();
    load_node(10'd0,    {24'sd0, 24'sd0, 24'sd0});
    load_node(10'd1023, {COORD_MAX, COORD_MAX, COORD_MAX});
    load_node(10'd512,  {COORD_MIN, COORD_MIN, COORD_MIN});
    load_node(10'd1,    {24'sd256, 24'sd0, 24'sd0});
    load_node(10'd2,    {24'sd0, 24'sd256, 24'sd0});
    load_node(10'd3,    {COORD_MAX, COORD_MIN, COORD_MAX});
    load_node(10'd4,    {COORD_MIN, COORD_MAX, COORD_MIN});
    query_facet(10'd0, 10'd1, 10'd2, 1'b0);
    query_facet(10'd0, 10'd1, 10'd2, 1'b1);
    // coincident corners with a zero threshold
    query_facet(10'd0, 10'd0, 10'd1, 1'b0);
    query_facet(10'd0, 10'd0, 10'd0, 1'b0);
    query_facet(10'd1, 10'd2, 10'd2, 1'b1);
    // full-scale edges, collinear in the first query
    query_facet(10'd1023, 10'd512, 10'd0, 1'b0);
    query_facet(10'd1023, 10'd512, 10'd3, 1'b0);
    query_facet(10'd3, 10'd4, 10'd1023, 1'b1);
    query_facet(10'd512, 10'd4, 10'd1023, 1'b0);
    query_facet(10'd4, 10'd3, 10'd512, 1'b1);
  endtask

  // an edge whose squared length equals the threshold is too short
  task automatic test_threshold_boundary();
    drain_pipeline();
    write_threshold(THR_BITS'(100));
    load_node(10'd5, {24'sd10, 24'sd0, 24'sd0});
    load_node(10'd6, {24'sd0, 24'sd0, 24'sd0});
    load_node(10'd7, {24'sd0, 24'sd20, 24'sd0});
    query_facet(10'd6, 10'd5, 10'd7, 1'b0);
    drain_pipeline();
    write_threshold(THR_BITS'(99));
    query_facet(10'd6, 10'd5, 10'd7, 1'b0);
    query_facet(10'd6, 10'd5, 10'd7, 1'b1);
  endtask

  task automatic test_random_mesh(input int n_items, input logic [THR_BITS-1:0] thr,
                                  input bit quiet, input bit hold_midway);
    logic [IDX_BITS-1:0] a, b, c;
    drain_pipeline();
    write_threshold(thr);
    steady = quiet;
    for (int i = 0; i < n_items; i++) begin
      if (hold_midway && i == n_items / 2) drain_pipeline();
      if ($urandom_range(99) < 30) begin
        load_node(IDX_BITS'($urandom_range(NODE_COUNT - 1)), rand_node());
      end else begin
        a = pick_loaded();
        b = pick_loaded();
        c = pick_loaded();
        case ($urandom_range(9))
          0:       b = a;
          1:       c = b;
          default: ;
        endcase
        query_facet(a, b, c, 1'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    rst_n            = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_LOAD;
    in_ch.node_index = '0;
    in_ch.point_x    = '0;
    in_ch.point_y    = '0;
    in_ch.point_z    = '0;
    in_ch.corner_a   = '0;
    in_ch.corner_b   = '0;
    in_ch.corner_c   = '0;
    in_ch.reversed   = 1'b0;
    threshold_reg    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_threshold('0);
    test_directed_extremes();
    test_threshold_boundary();
    test_random_mesh(420, '0, 1'b0, 1'b0);
    test_random_mesh(420, THR_BITS'($urandom_range(8192)), 1'b1, 1'b0);
    test_random_mesh(380, THR_BITS'({$urandom_range(65535), $urandom}), 1'b0, 1'b0);
    test_random_mesh(220, THR_FULL, 1'b0, 1'b0);
    test_random_mesh(400, THR_BITS'($urandom_range(1 << 27)), 1'b0, 1'b1);
    drain_pipeline();

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tfn_pkg.sv
rtl/tfn_if.sv
rtl/tfn_ram.sv
rtl/triangle_facet_normal.sv
tb/sv/triangle_facet_normal_tb.sv
